/* rtl/q58_pkg.sv */
// Shared constants and float32 helper functions for the block dot-product unit.
// Depends on nothing; used by the lane, merge and top-level modules.
`default_nettype none
package q58_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned LANE_ELEMS = 8;
  localparam int unsigned LANE_SUM_W = 16;
  localparam int unsigned SUMI_W = 18;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  function automatic logic [31:0] round_pack(input logic sgn, input logic [47:0] sig,
                                             input logic signed [11:0] ex);
    logic [5:0] lz;
    logic [47:0] norm;
    logic signed [11:0] be;
    logic signed [11:0] sh;
    logic [6:0] s;
    logic [71:0] ext;
    logic [23:0] mant;
    logic [24:0] mr;
    logic [8:0] fld;
    logic [22:0] frac;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (sig[i]) lz = 6'(47 - i);
    end
    norm = sig << lz;
    be = ex + 12'sd174 - $signed({6'd0, lz});
    if (be >= 12'sd1) begin
      s = 7'd0;
      fld = be[8:0];
    end else begin
      sh = 12'sd1 - be;
      s = (sh > 12'sd72) ? 7'd72 : sh[6:0];
      fld = 9'd0;
    end
    ext = {norm, 24'd0} >> s;
    mant = ext[71:48];
    mr = {1'b0, mant} + 25'(ext[47] & ((|ext[46:0]) | mant[0]));
    frac = mr[22:0];
    if (mr[24]) begin
      frac = mr[23:1];
      fld = fld + 9'd1;
    end else if (fld == 9'd0 && mr[23]) begin
      fld = 9'd1;
    end
    if (be > 12'sd254 || fld >= 9'd255) begin
      return {sgn, 8'hFF, 23'd0};
    end
    return {sgn, fld[7:0], frac};
  endfunction

  function automatic logic [31:0] half_mul(input logic [15:0] a, input logic [15:0] b);
    logic sgn;
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [10:0] ma, mb;
    logic [5:0] ea, eb;
    sgn = a[15] ^ b[15];
    a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
    b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
    a_inf = (a[14:10] == 5'h1F) && (a[9:0] == 10'd0);
    b_inf = (b[14:10] == 5'h1F) && (b[9:0] == 10'd0);
    a_zero = (a[14:0] == 15'd0);
    b_zero = (b[14:0] == 15'd0);
    ma = {a[14:10] != 5'd0, a[9:0]};
    mb = {b[14:10] != 5'd0, b[9:0]};
    ea = (a[14:10] == 5'd0) ? 6'd1 : {1'b0, a[14:10]};
    eb = (b[14:10] == 5'd0) ? 6'd1 : {1'b0, b[14:10]};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return QNAN;
    if (a_inf || b_inf) return {sgn, 8'hFF, 23'd0};
    if (a_zero || b_zero) return {sgn, 31'd0};
    return round_pack(sgn, 48'(ma * mb),
                      $signed({6'd0, ea}) + $signed({6'd0, eb}) - 12'sd50);
  endfunction

  function automatic logic [31:0] int_scale(input logic signed [SUMI_W-1:0] si,
                                            input logic [31:0] sc);
    logic sgn;
    logic [SUMI_W-2:0] mag;
    logic [23:0] m;
    logic [8:0] e;
    sgn = sc[31] ^ si[SUMI_W-1];
    mag = si[SUMI_W-1] ? (SUMI_W-1)'(-si) : si[SUMI_W-2:0];
    m = {sc[30:23] != 8'd0, sc[22:0]};
    e = (sc[30:23] == 8'd0) ? 9'd1 : {1'b0, sc[30:23]};
    if (sc[30:23] == 8'hFF) begin
      if (sc[22:0] != 23'd0 || si == '0) return QNAN;
      return {sgn, 8'hFF, 23'd0};
    end
    if (si == '0 || sc[30:0] == 31'd0) return {sgn, 31'd0};
    return round_pack(sgn, 48'(mag * m), $signed({3'd0, e}) - 12'sd150);
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic a_nan, b_nan, a_inf, b_inf, swap, sbig;
    logic [23:0] ma, mb, mbig, msm;
    logic [8:0] ea, eb, ebig, esm;
    logic [8:0] d;
    logic [47:0] av, bf, bs, sum;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) return QNAN;
    if (a_inf) return a;
    if (b_inf) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    swap = {ea, ma} < {eb, mb};
    mbig = swap ? mb : ma;
    msm = swap ? ma : mb;
    ebig = swap ? eb : ea;
    esm = swap ? ea : eb;
    sbig = swap ? b[31] : a[31];
    d = ebig - esm;
    av = {1'b0, mbig, 23'd0};
    bf = {1'b0, msm, 23'd0};
    if (d >= 9'd48) begin
      bs = {47'd0, msm != 24'd0};
    end else begin
      bs = bf >> d;
      bs = bs | 48'((bs << d) != bf);
    end
    sum = (a[31] == b[31]) ? av + bs : av - bs;
    if (sum == 48'd0) return 32'd0;
    return round_pack(sbig, sum, $signed({3'd0, ebig}) - 12'sd173);
  endfunction

endpackage
`default_nettype wire

/* rtl/q58_lane.sv */
// One lane: signed dot product of eight 5-bit codes with eight int8 values.
// Depends on q58_pkg for the lane widths.
`default_nettype none
module q58_lane
  import q58_pkg::*;
(
  input  wire logic [63:0]                 nib_bytes,
  input  wire logic                        upper,
  input  wire logic [LANE_ELEMS-1:0]       high_bits,
  input  wire logic [63:0]                 y_bytes,
  output logic signed [LANE_SUM_W-1:0]     lane_sum
);

  always_comb begin
    logic [3:0] nib;
    logic signed [5:0] xv;
    logic signed [7:0] yv;
    lane_sum = '0;
    for (int i = 0; i < LANE_ELEMS; i++) begin
      nib = upper ? nib_bytes[8*i+4 +: 4] : nib_bytes[8*i +: 4];
      xv = $signed({1'b0, high_bits[i], nib}) - 6'sd16;
      yv = $signed(y_bytes[8*i +: 8]);
      lane_sum = lane_sum + LANE_SUM_W'(xv * yv);
    end
  end

endmodule
`default_nettype wire

/* rtl/q58_merge.sv */
// Merging stage: registered sum of the lane results into the block integer dot.
// Depends on q58_pkg for the lane count and widths.
`default_nettype none
module q58_merge
  import q58_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [LANES*LANE_SUM_W-1:0]   lane_sums,
  output logic signed [SUMI_W-1:0]           sumi_r
);

  logic signed [SUMI_W-1:0] sumi_nxt;

  always_comb begin
    sumi_nxt = '0;
    for (int l = 0; l < LANES; l++) begin
      sumi_nxt = sumi_nxt + SUMI_W'($signed(lane_sums[l*LANE_SUM_W +: LANE_SUM_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) sumi_r <= sumi_nxt;
  end

endmodule
`default_nettype wire

/* rtl/q5_0_q8_0_block_dot_product.sv */
// Block dot-product accumulator: 5-bit by 8-bit block pairs into a float32 sum.
// An item passes through lanes and scale product, lane merge, scaling multiply,
// and the float32 add that closes the accumulation loop; a new item is taken after the add.
// A final pair's result appears in the cycle after its add and waits in an output register.
// Synchronous active-low reset clears the running sum to +0.0 and empties the output.
`default_nettype none
module q5_0_q8_0_block_dot_product
  import q58_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_x_scale,
  input  wire logic [31:0] in_x_high_bits,
  input  wire logic [63:0] in_x_low_first,
  input  wire logic [63:0] in_x_low_second,
  input  wire logic [15:0] in_y_scale,
  input  wire logic [63:0] in_y_quant_a,
  input  wire logic [63:0] in_y_quant_b,
  input  wire logic [63:0] in_y_quant_c,
  input  wire logic [63:0] in_y_quant_d,
  input  wire logic        in_final_pair,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_dot_sum
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MERGE = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_ADD   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [LANES*LANE_SUM_W-1:0] lane_sums, lane_sums_r;
  logic signed [SUMI_W-1:0] sumi_r;
  logic [31:0] scale_r, term_r, running_r, acc;
  logic final_r, out_valid_r;
  logic [31:0] out_dot_sum_r;
  logic accept, add_go;

  assign in_ready = (state_r == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_dot_sum = out_dot_sum_r;

  q58_lane u_lane0 (.nib_bytes(in_x_low_first), .upper(1'b0),
    .high_bits(in_x_high_bits[7:0]), .y_bytes(in_y_quant_a),
    .lane_sum(lane_sums[0*LANE_SUM_W +: LANE_SUM_W]));
  q58_lane u_lane1 (.nib_bytes(in_x_low_second), .upper(1'b0),
    .high_bits(in_x_high_bits[15:8]), .y_bytes(in_y_quant_b),
    .lane_sum(lane_sums[1*LANE_SUM_W +: LANE_SUM_W]));
  q58_lane u_lane2 (.nib_bytes(in_x_low_first), .upper(1'b1),
    .high_bits(in_x_high_bits[23:16]), .y_bytes(in_y_quant_c),
    .lane_sum(lane_sums[2*LANE_SUM_W +: LANE_SUM_W]));
  q58_lane u_lane3 (.nib_bytes(in_x_low_second), .upper(1'b1),
    .high_bits(in_x_high_bits[31:24]), .y_bytes(in_y_quant_d),
    .lane_sum(lane_sums[3*LANE_SUM_W +: LANE_SUM_W]));

  q58_merge u_merge (.clk(clk), .load(state_r == ST_MERGE),
    .lane_sums(lane_sums_r), .sumi_r(sumi_r));

  assign acc = f32_add(running_r, term_r);
  assign add_go = (state_r == ST_ADD) && (!final_r || !out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD:   if (add_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lane_sums_r <= lane_sums;
      scale_r <= half_mul(in_x_scale, in_y_scale);
      final_r <= in_final_pair;
    end
    if (state_r == ST_MUL) term_r <= int_scale(sumi_r, scale_r);
    if (add_go && final_r) out_dot_sum_r <= acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      running_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (add_go) begin
        running_r <= final_r ? 32'd0 : acc;
      end
      if (add_go && final_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* test/tb_q5_0_q8_0_block_dot_product.sv */
// Self-checking testbench for the Q5_0 x Q8_0 block dot-product accumulator.
// Drives directed and random block-pair requests, predicts float32 sums exactly
// with wide integer arithmetic, and depends only on q58_pkg and the top level.
module tb_q5_0_q8_0_block_dot_product;
  import q58_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PAIRS = 1750;

  typedef struct packed {
    logic [15:0] xs;
    logic [31:0] xh;
    logic [63:0] xl1;
    logic [63:0] xl2;
    logic [15:0] ys;
    logic [63:0] ya;
    logic [63:0] yb;
    logic [63:0] yc;
    logic [63:0] yd;
    logic        fin;
  } pair_t;

  typedef struct packed {
    pair_t       p;
    logic        known;
    logic [31:0] want;
  } row_t;

  localparam logic [63:0] ONES = 64'h0101_0101_0101_0101;
  localparam logic [63:0] P127 = 64'h7F7F_7F7F_7F7F_7F7F;
  localparam logic [63:0] N128 = 64'h8080_8080_8080_8080;
  localparam logic [63:0] FFS = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIXA = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] MIXB = 64'hF0E1_D2C3_B4A5_9687;

  localparam int NUM_ROWS = 16;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{16'h0000, 32'h0, 64'h0, 64'h0, 16'h0000, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1},
      1'b1, 32'h0000_0000},
    '{'{16'h3C00, 32'h0, 64'h0, 64'h0, 16'h3C00, ONES, ONES, ONES, ONES, 1'b1},
      1'b1, 32'hC400_0000},
    '{'{16'h3C00, 32'hFFFF_FFFF, FFS, FFS, 16'h3C00, P127, P127, P127, P127, 1'b1},
      1'b1, 32'h476E_2000},
    '{'{16'h3C00, 32'h0, 64'h0, 64'h0, 16'h3C00, N128, N128, N128, N128, 1'b1},
      1'b1, 32'h4780_0000},
    '{'{16'h7E00, 32'h0, 64'h0, 64'h0, 16'h3C00, ONES, ONES, ONES, ONES, 1'b1},
      1'b1, QNAN},
    '{'{16'h7C00, 32'h0, 64'h0, 64'h0, 16'h3C00, ONES, ONES, ONES, ONES, 1'b1},
      1'b1, 32'hFF80_0000},
    '{'{16'h7C00, 32'h0, 64'h0, 64'h0, 16'h0000, ONES, ONES, ONES, ONES, 1'b1},
      1'b1, QNAN},
    '{'{16'h3C00, 32'hFFFF_FFFF, FFS, FFS, 16'h3C00, P127, P127, P127, P127, 1'b0},
      1'b0, 32'h0},
    '{'{16'h3C00, 32'hFFFF_FFFF, FFS, FFS, 16'hBC00, P127, P127, P127, P127, 1'b1},
      1'b1, 32'h0000_0000},
    '{'{16'h8000, 32'hFFFF_FFFF, FFS, FFS, 16'h3C00, P127, P127, P127, P127, 1'b1},
      1'b1, 32'h0000_0000},
    '{'{16'h7C00, 32'hFFFF_FFFF, FFS, FFS, 16'h3C00, P127, P127, P127, P127, 1'b0},
      1'b0, 32'h0},
    '{'{16'hFC00, 32'hFFFF_FFFF, FFS, FFS, 16'h3C00, P127, P127, P127, P127, 1'b1},
      1'b1, QNAN},
    '{'{16'h0001, 32'h5555_AAAA, MIXA, MIXB, 16'h03FF, MIXB, MIXA, N128, P127, 1'b0},
      1'b0, 32'h0},
    '{'{16'h7BFF, 32'hFFFF_FFFF, FFS, FFS, 16'h7BFF, N128, N128, N128, N128, 1'b1},
      1'b0, 32'h0},
    '{'{16'h3555, 32'hA5A5_0F0F, MIXB, MIXA, 16'hC123, MIXA, FFS, ONES, MIXB, 1'b0},
      1'b0, 32'h0},
    '{'{16'h0400, 32'h1234_5678, MIXA, FFS, 16'h8001, P127, MIXB, MIXA, N128, 1'b1},
      1'b0, 32'h0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pair_t       drv;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_dot_sum;

  logic [31:0] sum_state;
  logic [31:0] expected_sums [$];
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          quiet_cycles;
  bit          failed;

  q5_0_q8_0_block_dot_product i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_x_scale     (drv.xs),
    .in_x_high_bits (drv.xh),
    .in_x_low_first (drv.xl1),
    .in_x_low_second(drv.xl2),
    .in_y_scale     (drv.ys),
    .in_y_quant_a   (drv.ya),
    .in_y_quant_b   (drv.yb),
    .in_y_quant_c   (drv.yc),
    .in_y_quant_d   (drv.yd),
    .in_final_pair  (drv.fin),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dot_sum    (out_dot_sum)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Value is mag * 2^ex; rounded to nearest even float32.
  function automatic logic [31:0] to_f32(input logic sgn, input logic [299:0] mag,
                                         input int ex);
    int msb;
    int lsb_ex;
    int sh;
    logic [299:0] mant;
    logic [299:0] rem;
    logic [299:0] half;
    logic [7:0] biased;
    msb = -1;
    for (int i = 0; i < 300; i++) begin
      if (mag[i]) msb = i;
    end
    if (msb < 0) return {sgn, 31'd0};
    if (msb + ex > 127) return {sgn, 8'hFF, 23'd0};
    lsb_ex = (msb + ex - 23 > -149) ? msb + ex - 23 : -149;
    sh = lsb_ex - ex;
    if (sh <= 0) begin
      mant = mag << (-sh);
    end else begin
      mant = mag >> sh;
      rem = mag - (mant << sh);
      half = 300'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 1;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      lsb_ex++;
    end
    if (lsb_ex + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    biased = mant[23] ? 8'(lsb_ex + 150) : 8'd0;
    return {sgn, biased, mant[22:0]};
  endfunction

  function automatic void split_f32(input logic [31:0] f, output logic [23:0] m,
                                    output int ex);
    if (f[30:23] == 8'd0) begin
      m = {1'b0, f[22:0]};
      ex = -149;
    end else begin
      m = {1'b1, f[22:0]};
      ex = int'(f[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] scale_product(input logic [15:0] a, input logic [15:0] b);
    logic sgn;
    logic [10:0] ma, mb;
    int ea, eb;
    sgn = a[15] ^ b[15];
    if ((a[14:10] == 5'h1F && a[9:0] != 0) || (b[14:10] == 5'h1F && b[9:0] != 0) ||
        (a[14:10] == 5'h1F && b[14:0] == 0) || (b[14:10] == 5'h1F && a[14:0] == 0))
      return QNAN;
    if (a[14:10] == 5'h1F || b[14:10] == 5'h1F) return {sgn, 8'hFF, 23'd0};
    ma = {a[14:10] != 0, a[9:0]};
    mb = {b[14:10] != 0, b[9:0]};
    ea = (a[14:10] == 0) ? -24 : int'(a[14:10]) - 25;
    eb = (b[14:10] == 0) ? -24 : int'(b[14:10]) - 25;
    return to_f32(sgn, 300'(ma) * 300'(mb), ea + eb);
  endfunction

  function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
    logic [23:0] ma, mb;
    int ea, eb, emin;
    logic [299:0] va, vb;
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
      return QNAN;
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return QNAN;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    emin = (ea < eb) ? ea : eb;
    va = 300'(ma) << (ea - emin);
    vb = 300'(mb) << (eb - emin);
    if (a[31] == b[31]) return to_f32(a[31], va + vb, emin);
    if (va == vb) return 32'd0;
    if (va > vb) return to_f32(a[31], va - vb, emin);
    return to_f32(b[31], vb - va, emin);
  endfunction

  // Advances the running sum by one pair; returns the new sum.
  function automatic logic [31:0] accumulate_pair(input pair_t p);
    logic [127:0] nibbles;
    logic [255:0] yvals;
    logic [7:0] byte_val;
    logic [4:0] code;
    int sumi;
    logic [31:0] sc, term, acc;
    logic [23:0] ms;
    int es;
    logic neg;
    nibbles = {p.xl2, p.xl1};
    yvals = {p.yd, p.yc, p.yb, p.ya};
    sumi = 0;
    for (int j = 0; j < 32; j++) begin
      byte_val = nibbles[8 * (j % 16) +: 8];
      code = {p.xh[j], (j < 16) ? byte_val[3:0] : byte_val[7:4]};
      sumi += (int'(code) - 16) * int'($signed(yvals[8 * j +: 8]));
    end
    sc = scale_product(p.xs, p.ys);
    neg = sumi < 0;
    if (sc[30:23] == 8'hFF && (sc[22:0] != 0 || sumi == 0)) term = QNAN;
    else if (sc[30:23] == 8'hFF) term = {sc[31] ^ neg, 8'hFF, 23'd0};
    else if (sumi == 0 || sc[30:0] == 0) term = {sc[31] ^ neg, 31'd0};
    else begin
      split_f32(sc, ms, es);
      term = to_f32(sc[31] ^ neg, 300'(neg ? -sumi : sumi) * 300'(ms), es);
    end
    acc = add_f32(sum_state, term);
    if (acc[30:23] == 8'hFF && acc[22:0] != 0) acc = QNAN;
    return acc;
  endfunction

  function automatic logic [15:0] random_half();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return {1'($urandom), 5'($urandom_range(20, 9)), 10'($urandom)};
    if (pick < 88) return 16'($urandom);
    case ($urandom_range(4))
      0: return {1'($urandom), 15'd0};
      1: return {1'($urandom), 5'd0, 10'($urandom)};
      2: return {1'($urandom), 5'h1F, 10'd0};
      3: return {1'($urandom), 5'h1F, 10'($urandom_range(1023, 1))};
      default: return {1'($urandom), 5'h1E, 10'h3FF};
    endcase
  endfunction

  task automatic send_pair(input pair_t p, input logic known, input logic [31:0] want);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    drv <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sum_state = accumulate_pair(p);
    if (p.fin) begin
      expected_sums.push_back(known ? want : sum_state);
      sum_state = 32'd0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_dot_sum);
        failed = 1'b1;
      end else begin
        if (out_dot_sum !== expected_sums[0]) begin
          $display("%0t: dot_sum mismatch, expected %h, actual %h", $time,
                   expected_sums[0], out_dot_sum);
          failed = 1'b1;
        end
        void'(expected_sums.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int run_len;
    int phase_pairs;
    pair_t p;
    sum_state = 32'd0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_pair(DIRECTED_ROWS[r].p, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
      phase_pairs = RANDOM_PAIRS / 4;
      sent = 0;
      while (sent < phase_pairs) begin
        run_len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        if (run_len > phase_pairs - sent) run_len = phase_pairs - sent;
        for (int k = 0; k < run_len; k++) begin
          p.xs = random_half();
          p.ys = random_half();
          p.xh = $urandom;
          p.xl1 = {$urandom, $urandom};
          p.xl2 = {$urandom, $urandom};
          p.ya = {$urandom, $urandom};
          p.yb = {$urandom, $urandom};
          p.yc = {$urandom, $urandom};
          p.yd = {$urandom, $urandom};
          if ($urandom_range(15) == 0) begin
            p.xh = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            p.ya = $urandom_range(1) ? P127 : N128;
            p.yc = p.ya;
          end
          p.fin = (k == run_len - 1);
          send_pair(p, 1'b0, 32'h0);
          sent++;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/q58_pkg.sv
rtl/q58_lane.sv
rtl/q58_merge.sv
rtl/q5_0_q8_0_block_dot_product.sv
test/tb_q5_0_q8_0_block_dot_product.sv
